/* hw/rtl/bmp_pixel_stream_to_rgb565_defines.svh */
// assertion macros shared by the bmp to rgb565 converter files
// expects a clock named clk and a synchronous active-high reset named rst in scope
`ifndef BMP_PIXEL_STREAM_TO_RGB565_DEFINES_SVH
`define BMP_PIXEL_STREAM_TO_RGB565_DEFINES_SVH

// checked only outside reset
`define BMPRGB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define BMPRGB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/bmprgb_pkg.sv */
// types, register codes and color helpers for the bmp to rgb565 converter
// used by every module of the block, no dependencies
`default_nettype none

package bmprgb_pkg;

  localparam int IMG_WIDTH_W = 13;

  typedef enum logic [1:0] {
    FMT_RGB555 = 2'd0,
    FMT_RGB565 = 2'd1,
    FMT_BGR24  = 2'd2,
    FMT_BGRX32 = 2'd3
  } pix_fmt_t;

  // configuration register indexes
  localparam logic CFG_PIXEL_FORMAT = 1'b0;
  localparam logic CFG_IMAGE_WIDTH  = 1'b1;

  localparam pix_fmt_t                  PIXEL_FORMAT_RST = FMT_RGB565;
  localparam logic [IMG_WIDTH_W-1:0]    IMAGE_WIDTH_RST  = 13'd320;

  localparam logic [15:0] RGB555_RED_MASK   = 16'h7C00;
  localparam logic [15:0] RGB555_GREEN_MASK = 16'h03E0;
  localparam logic [15:0] RGB555_BLUE_MASK  = 16'h001F;

  typedef struct packed {
    logic [7:0] pixel_byte;
    logic       start_of_image;
  } src_item_t;

  typedef struct packed {
    logic [15:0] pixel_rgb565;
    logic        row_end;
  } dst_item_t;

  typedef struct packed {
    pix_fmt_t                 pixel_format;
    logic [IMG_WIDTH_W-1:0]   image_width;
  } cfg_t;

  // input register contents handed to the converter
  typedef struct packed {
    logic      valid;
    src_item_t item;
  } stage_t;

  function automatic logic [15:0] from_rgb555(input logic [15:0] w);
    from_rgb555 = ((w & RGB555_RED_MASK) << 1) | ((w & RGB555_GREEN_MASK) << 1)
                | (w & RGB555_BLUE_MASK);
  endfunction

  function automatic logic [15:0] from_bgr(input logic [7:0] b, input logic [7:0] g,
                                           input logic [7:0] r);
    from_bgr = {r[7:3], g[7:2], b[7:3]};
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/bmprgb_in_stage.sv */
// input register of the bmp to rgb565 converter
// uses bmprgb_pkg and the assertion macros header
`default_nettype none

`include "bmp_pixel_stream_to_rgb565_defines.svh"

module bmprgb_in_stage (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 src_valid,
  output logic                      src_ready,
  input  wire bmprgb_pkg::src_item_t src_item,
  input  wire logic                 take,
  output bmprgb_pkg::stage_t        stage
);

  logic                  valid;
  bmprgb_pkg::src_item_t item;

  // refill in the same cycle the held item moves on
  assign src_ready = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (src_ready) begin
      valid <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (src_valid && src_ready) begin
      item <= src_item;
    end
  end

  assign stage.valid = valid;
  assign stage.item  = item;

  `BMPRGB_ASSERT(a_hold_item, valid && !take |=> valid && $stable(item), "held item lost")
  `BMPRGB_ASSERT_ALWAYS(a_take_valid, take |-> valid, "take without an item")

endmodule

`default_nettype wire

/* hw/rtl/bmprgb_conv.sv */
// byte phase / row tracking, color conversion and result register
// uses bmprgb_pkg and the assertion macros header
`default_nettype none

`include "bmp_pixel_stream_to_rgb565_defines.svh"

module bmprgb_conv #(
  parameter int MAX_WIDTH = 4096
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire bmprgb_pkg::cfg_t     cfg,
  input  wire bmprgb_pkg::stage_t   stage,
  output logic                      take,
  output logic                      dst_valid,
  input  wire logic                 dst_ready,
  output bmprgb_pkg::dst_item_t     dst_item
);

  localparam int WMAX      = (MAX_WIDTH < 8191) ? MAX_WIDTH : 8191;
  localparam int POS_LIMIT = 4 * WMAX;
  localparam int PW        = $clog2(POS_LIMIT + 1);

  logic [1:0]    byte_phase, byte_phase_next;
  logic [PW-1:0] row_byte_position, row_byte_position_next;
  logic [15:0]   held_bytes, held_bytes_next;

  logic [bmprgb_pkg::IMG_WIDTH_W-1:0] width_eff;
  logic [2:0]    bpp, ncol, ph_inc;
  logic [15:0]   vis_full, pad_full;
  logic [PW-1:0] visible, padded;
  logic [1:0]    phase0, ph;
  logic [PW-1:0] pos0;
  logic [15:0]   held0;
  logic [7:0]    pbyte;
  logic          in_row, store, emit, row_end;
  logic [PW:0]   pos_inc;
  logic [15:0]   pix;

  assign take  = stage.valid && (!dst_valid || dst_ready);
  assign pbyte = stage.item.pixel_byte;

  always_comb begin
    if (cfg.image_width == '0) begin
      width_eff = bmprgb_pkg::IMG_WIDTH_W'(1);
    end else if (32'(cfg.image_width) > MAX_WIDTH) begin
      width_eff = bmprgb_pkg::IMG_WIDTH_W'(WMAX);
    end else begin
      width_eff = cfg.image_width;
    end
  end

  always_comb begin
    unique case (cfg.pixel_format) inside
      bmprgb_pkg::FMT_RGB555, bmprgb_pkg::FMT_RGB565: begin
        bpp      = 3'd2;
        ncol     = 3'd2;
        vis_full = {2'b00, width_eff, 1'b0};
      end
      bmprgb_pkg::FMT_BGR24: begin
        bpp      = 3'd3;
        ncol     = 3'd3;
        vis_full = {2'b00, width_eff, 1'b0} + {3'b000, width_eff};
      end
      default: begin
        bpp      = 3'd4;
        ncol     = 3'd3;
        vis_full = {1'b0, width_eff, 2'b00};
      end
    endcase
  end

  // rows are padded up to a multiple of four bytes
  assign pad_full = (vis_full + 16'd3) & ~16'd3;
  assign visible  = PW'(vis_full);
  assign padded   = PW'(pad_full);

  // start of image clears the row state ahead of this byte
  assign phase0 = stage.item.start_of_image ? 2'd0 : byte_phase;
  assign pos0   = stage.item.start_of_image ? '0 : row_byte_position;
  assign held0  = stage.item.start_of_image ? 16'd0 : held_bytes;

  assign ph     = ({1'b0, phase0} >= bpp) ? 2'd0 : phase0;
  assign ph_inc = {1'b0, ph} + 3'd1;
  assign in_row = pos0 < visible;
  assign store  = in_row && (ph_inc < ncol);
  assign emit   = in_row && (ph_inc == ncol);
  assign row_end = ({1'b0, pos0} + (PW+1)'(bpp - {1'b0, ph})) == {1'b0, visible};

  always_comb begin
    case (cfg.pixel_format)
      bmprgb_pkg::FMT_RGB555: pix = bmprgb_pkg::from_rgb555({pbyte, held0[7:0]});
      bmprgb_pkg::FMT_RGB565: pix = {pbyte, held0[7:0]};
      default:                pix = bmprgb_pkg::from_bgr(held0[7:0], held0[15:8], pbyte);
    endcase
  end

  always_comb begin
    held_bytes_next = held0;
    if (store) begin
      held_bytes_next = (ph == 2'd0) ? {8'h00, pbyte} : {pbyte, held0[7:0]};
    end
    if (!in_row || ph_inc >= bpp) begin
      byte_phase_next = 2'd0;
    end else begin
      byte_phase_next = ph_inc[1:0];
    end
    pos_inc = {1'b0, pos0} + (PW+1)'(1);
    row_byte_position_next = (pos_inc >= {1'b0, padded}) ? '0 : pos_inc[PW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_phase        <= 2'd0;
      row_byte_position <= '0;
      held_bytes        <= 16'd0;
      dst_valid         <= 1'b0;
    end else begin
      if (take) begin
        byte_phase        <= byte_phase_next;
        row_byte_position <= row_byte_position_next;
        held_bytes        <= held_bytes_next;
        dst_valid         <= emit;
      end else if (dst_ready) begin
        dst_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      dst_item.pixel_rgb565 <= pix;
      dst_item.row_end      <= row_end;
    end
  end

  `BMPRGB_ASSERT(a_pos_bound, 32'(row_byte_position) < POS_LIMIT, "row position out of range")
  `BMPRGB_ASSERT(a_held_low, byte_phase == 2'd1 |-> held_bytes[15:8] == 8'h00,
                 "stale high byte at second phase")
  `BMPRGB_ASSERT(a_new_result, dst_valid && !$past(dst_valid && !dst_ready) |-> $past(take),
                 "result without an item")

endmodule

`default_nettype wire

/* hw/rtl/bmp_pixel_stream_to_rgb565.sv */
// top level of the bmp pixel stream to rgb565 converter
// uses bmprgb_pkg, bmprgb_in_stage and bmprgb_conv
//
//   channel | handshake              | payload
//   src     | src_valid / src_ready  | src_item  (pixel_byte, start_of_image)
//   dst     | dst_valid / dst_ready  | dst_item  (pixel_rgb565, row_end)
//   cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// one byte per cycle sustained while dst does not stall; a pixel passes from its last color byte
// through the input register and then the result register around the converter
// synchronous reset clears row state and loads pixel_format 1, image_width 320
// a stalled dst holds the result and backs up src once the input register is full
// cfg writes are always taken
`default_nettype none

module bmp_pixel_stream_to_rgb565 #(
  parameter int MAX_WIDTH = 4096
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          src_valid,
  output logic                               src_ready,
  input  wire bmprgb_pkg::src_item_t         src_item,
  output logic                               dst_valid,
  input  wire logic                          dst_ready,
  output bmprgb_pkg::dst_item_t              dst_item,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic                          cfg_index,
  input  wire logic [bmprgb_pkg::IMG_WIDTH_W-1:0] cfg_data
);

  bmprgb_pkg::cfg_t   cfg;
  bmprgb_pkg::stage_t stage;
  logic               take;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pixel_format <= bmprgb_pkg::PIXEL_FORMAT_RST;
      cfg.image_width  <= bmprgb_pkg::IMAGE_WIDTH_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        bmprgb_pkg::CFG_PIXEL_FORMAT: cfg.pixel_format <= bmprgb_pkg::pix_fmt_t'(cfg_data[1:0]);
        bmprgb_pkg::CFG_IMAGE_WIDTH:  cfg.image_width  <= cfg_data;
        default: ;
      endcase
    end
  end

  bmprgb_in_stage u_in_stage (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_ready (src_ready),
    .src_item  (src_item),
    .take      (take),
    .stage     (stage)
  );

  bmprgb_conv #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_conv (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .stage     (stage),
    .take      (take),
    .dst_valid (dst_valid),
    .dst_ready (dst_ready),
    .dst_item  (dst_item)
  );

endmodule

`default_nettype wire
